// File: rtl/core/kvcp_pkg.sv
// ----------------------------------------------------------------------------
// kvcp_pkg: shared types and constants of the key/value line parser
// Holds the transfer payload types of both channels and the record that
// carries the writes of one byte from the parser to the result queue.
// ----------------------------------------------------------------------------
package kvcp_pkg;

  localparam int VAL_MAX_DEFAULT = 16;

  localparam logic [1:0] TARGET_INKS = 2'd3;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_buffer;
  } byte_t;

  typedef struct packed {
    logic [1:0] target;
    logic [4:0] position;
    logic [7:0] value;
    logic       last_of_run;
  } result_t;

  // Writes caused by one accepted byte: zero, one or two of them.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

// File: rtl/core/kvcp_parser.sv
// ----------------------------------------------------------------------------
// kvcp_parser: per-byte parse state and write generation
// Updates the line/key/value state for each accepted byte and produces the
// string or ink table writes that the byte causes.
// ----------------------------------------------------------------------------
module kvcp_parser
  import kvcp_pkg::*;
#(
  parameter int VAL_MAX = VAL_MAX_DEFAULT
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  accept,
  input  byte_t data,
  output push_t push
);

  localparam int CW = $clog2(VAL_MAX + 1);

  localparam logic [2:0] MODE_LINE = 3'd0;
  localparam logic [2:0] MODE_SKIP = 3'd1;
  localparam logic [2:0] MODE_KEY  = 3'd2;
  localparam logic [2:0] MODE_COPY = 3'd3;
  localparam logic [2:0] MODE_INKS = 3'd4;

  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [4:0] INK_CAP    = 5'd26;
  localparam logic [2:0] NPENS      = 3'd5;

  localparam logic [7:0][7:0] KEY_ICONS  = {"ICONS=", 16'h0000};
  localparam logic [7:0][7:0] KEY_FONT   = {"FONT=", 24'h000000};
  localparam logic [7:0][7:0] KEY_CURSOR = {"CURSOR=", 8'h00};
  localparam logic [7:0][7:0] KEY_INKS   = {"INKS=", 24'h000000};

  function automatic logic [7:0] key_char(input logic [1:0] k, input logic [2:0] p);
    logic [2:0] idx;
    idx = 3'd7 - p;
    case (k)
      2'd0:    key_char = KEY_ICONS[idx];
      2'd1:    key_char = KEY_FONT[idx];
      2'd2:    key_char = KEY_CURSOR[idx];
      default: key_char = KEY_INKS[idx];
    endcase
  endfunction

  function automatic logic [2:0] key_len(input logic [1:0] k);
    case (k)
      2'd0:    key_len = 3'd6;
      2'd1:    key_len = 3'd5;
      2'd2:    key_len = 3'd7;
      default: key_len = 3'd5;
    endcase
  endfunction

  function automatic logic [4:0] pos5(input logic [CW-1:0] cnt);
    logic [CW+4:0] ext;
    ext = {5'd0, cnt};
    pos5 = ext[4:0];
  endfunction

  logic [2:0]    mode, mode_next;
  logic [2:0]    key_position, key_position_next;
  logic [3:0]    key_candidates, key_candidates_next;
  logic [1:0]    value_target, value_target_next;
  logic [CW-1:0] copy_count, copy_count_next;
  logic [2:0]    pen_index, pen_index_next;
  logic [4:0]    ink_accumulator, ink_accumulator_next;
  logic          digit_seen, digit_seen_next;

  always_comb begin
    logic [7:0]    c;
    logic          eol;
    logic [3:0]    base_cand;
    logic [2:0]    base_pos;
    logic [3:0]    keep;
    logic          started;
    logic          do_key;
    logic [8:0]    prod;
    logic [CW-1:0] cnt_inc;
    logic          e1, e2, e3;
    result_t       d1, d2, d3;

    c   = data.text_byte;
    eol = (c == CHAR_CR) || (c == CHAR_LF);

    mode_next            = mode;
    key_position_next    = key_position;
    key_candidates_next  = key_candidates;
    value_target_next    = value_target;
    copy_count_next      = copy_count;
    pen_index_next       = pen_index;
    ink_accumulator_next = ink_accumulator;
    digit_seen_next      = digit_seen;

    e1 = 1'b0;
    e2 = 1'b0;
    e3 = 1'b0;
    d1 = '0;
    d2 = '0;
    d3 = '0;
    do_key    = 1'b0;
    base_cand = key_candidates;
    base_pos  = key_position;
    keep      = '0;
    started   = 1'b0;
    prod      = '0;
    cnt_inc   = copy_count + CW'(1);

    case (mode)
      MODE_LINE: begin
        if (eol) begin
          mode_next = MODE_LINE;
        end else if (c == CHAR_HASH) begin
          mode_next = MODE_SKIP;
        end else begin
          base_cand = 4'hF;
          base_pos  = 3'd0;
          do_key    = 1'b1;
        end
      end
      MODE_KEY: begin
        do_key = 1'b1;
      end
      MODE_COPY: begin
        if (c == 8'd0 || eol) begin
          e1 = 1'b1;
          d1 = '{target: value_target, position: pos5(copy_count), value: 8'd0,
                 last_of_run: 1'b0};
          mode_next = eol ? MODE_LINE : MODE_SKIP;
        end else begin
          e1 = 1'b1;
          d1 = '{target: value_target, position: pos5(copy_count), value: c,
                 last_of_run: 1'b0};
          copy_count_next = cnt_inc;
          if (cnt_inc >= CW'(VAL_MAX)) begin
            e2 = 1'b1;
            d2 = '{target: value_target, position: pos5(cnt_inc), value: 8'd0,
                   last_of_run: 1'b0};
            mode_next = MODE_SKIP;
          end
        end
      end
      MODE_INKS: begin
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
          prod = {4'd0, ink_accumulator} * 9'd10 + {5'd0, c[3:0]};
          ink_accumulator_next = (prod > {4'd0, INK_CAP}) ? INK_CAP : prod[4:0];
          digit_seen_next = 1'b1;
        end else begin
          if (digit_seen) begin
            e1 = 1'b1;
            d1 = '{target: TARGET_INKS, position: {2'd0, pen_index},
                   value: {3'd0, ink_accumulator}, last_of_run: 1'b0};
          end
          digit_seen_next      = 1'b0;
          ink_accumulator_next = '0;
          if (eol) begin
            mode_next = MODE_LINE;
          end else if (c == CHAR_COMMA) begin
            pen_index_next = pen_index + 3'd1;
            if (pen_index + 3'd1 >= NPENS) begin
              mode_next = MODE_SKIP;
            end
          end else begin
            mode_next = MODE_SKIP;
          end
        end
      end
      default: begin
        if (eol) begin
          mode_next = MODE_LINE;
        end
      end
    endcase

    if (do_key) begin
      for (int k = 0; k < 4; k++) begin
        if (base_cand[k] && base_pos < key_len(2'(k)) && key_char(2'(k), base_pos) == c) begin
          keep[k] = 1'b1;
        end
      end
      key_candidates_next = keep;
      key_position_next   = base_pos + 3'd1;
      if (keep == 4'd0) begin
        mode_next = eol ? MODE_LINE : MODE_SKIP;
      end else begin
        mode_next = MODE_KEY;
        for (int k = 0; k < 4; k++) begin
          if (!started && keep[k] && key_len(2'(k)) == base_pos + 3'd1) begin
            started = 1'b1;
            if (2'(k) == TARGET_INKS) begin
              mode_next            = MODE_INKS;
              pen_index_next       = 3'd0;
              ink_accumulator_next = '0;
              digit_seen_next      = 1'b0;
            end else begin
              mode_next         = MODE_COPY;
              value_target_next = 2'(k);
              copy_count_next   = '0;
            end
          end
        end
      end
    end

    // The final byte flushes a pending value and returns to line start.
    if (data.end_of_buffer) begin
      if (mode_next == MODE_COPY) begin
        e3 = 1'b1;
        d3 = '{target: value_target_next, position: pos5(copy_count_next),
               value: 8'd0, last_of_run: 1'b0};
      end else if (mode_next == MODE_INKS && digit_seen_next) begin
        e3 = 1'b1;
        d3 = '{target: TARGET_INKS, position: {2'd0, pen_index_next},
               value: {3'd0, ink_accumulator_next}, last_of_run: 1'b0};
      end
      mode_next            = MODE_LINE;
      key_position_next    = 3'd0;
      key_candidates_next  = 4'hF;
      value_target_next    = 2'd0;
      copy_count_next      = '0;
      pen_index_next       = 3'd0;
      ink_accumulator_next = '0;
      digit_seen_next      = 1'b0;
    end

    // Pack the writes in order and flag the last one.
    push = '0;
    if (e1) begin
      push.first = d1;
      if (e2) begin
        push.second = d2;
        push.count  = 2'd2;
      end else if (e3) begin
        push.second = d3;
        push.count  = 2'd2;
      end else begin
        push.count = 2'd1;
      end
    end else if (e3) begin
      push.first = d3;
      push.count = 2'd1;
    end
    if (push.count == 2'd2) begin
      push.second.last_of_run = 1'b1;
    end else if (push.count == 2'd1) begin
      push.first.last_of_run = 1'b1;
    end
    if (!accept) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_LINE;
      key_position    <= 3'd0;
      key_candidates  <= 4'hF;
      value_target    <= 2'd0;
      copy_count      <= '0;
      pen_index       <= 3'd0;
      ink_accumulator <= '0;
      digit_seen      <= 1'b0;
    end else if (accept) begin
      mode            <= mode_next;
      key_position    <= key_position_next;
      key_candidates  <= key_candidates_next;
      value_target    <= value_target_next;
      copy_count      <= copy_count_next;
      pen_index       <= pen_index_next;
      ink_accumulator <= ink_accumulator_next;
      digit_seen      <= digit_seen_next;
    end
  end

endmodule

// File: rtl/core/kvcp_queue.sv
// ----------------------------------------------------------------------------
// kvcp_queue: four-entry result queue
// Takes up to two writes per cycle and presents them one per transfer.
// ----------------------------------------------------------------------------
module kvcp_queue
  import kvcp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    full,
  output logic    valid,
  input  logic    stall,
  output result_t data
);

  result_t    mem [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count, count_next;
  logic       pop;

  assign valid = (count != 3'd0);
  assign data  = mem[rd_ptr];
  assign pop   = valid && !stall;
  // Room for two entries must be there before a byte is taken.
  assign full  = (count > 3'd2);

  always_comb begin
    count_next = count + {1'b0, push.count} - {2'd0, pop};
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + 2'd1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push.count;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count_next;
    end
  end

endmodule

// File: rtl/core/key_value_config_line_parser.sv
// ----------------------------------------------------------------------------
// key_value_config_line_parser: streaming key/value configuration parser
// Reads configuration text one byte per transfer and emits string and ink
// table writes for the ICONS=, FONT=, CURSOR= and INKS= keys.
// ----------------------------------------------------------------------------
// Usage:
//   The byte channel (byte_valid, byte_stall, byte_data) carries one text
//   byte per transfer; end_of_buffer marks the final byte of the buffer.
//   The result channel (result_valid, result_stall, result_data) carries one
//   write per transfer; last_of_run marks the final write that a byte caused.
//   A byte causes zero, one or two writes.
//   A write is registered into the result queue when the byte that caused
//   it is transferred, and it is offered once the writes ahead of it are out.
//   Throughput: one byte per cycle while the receiver keeps up. The output
//   port drains one write per cycle, so bytes that cause two writes take two
//   transfers on the result side; the four-entry result queue absorbs this and
//   byte_stall rises only when fewer than two entries are free.
//   When the receiver stalls, queued writes hold and the parser keeps taking
//   bytes until the queue runs short of room.
//   Reset clears the parse state to line start with all keys possible and
//   empties the result queue.
// ----------------------------------------------------------------------------
module key_value_config_line_parser
  import kvcp_pkg::*;
#(
  parameter int VAL_MAX = VAL_MAX_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    byte_valid,
  output logic    byte_stall,
  input  byte_t   byte_data,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result_data
);

  logic  accept;
  push_t push;
  logic  queue_full;

  // A byte transfer happens when the queue has room for both possible writes.
  assign byte_stall = queue_full;
  assign accept     = byte_valid && !queue_full;

  // Parse state and write generation; all work for a byte is done in the
  // cycle it is transferred, so the parser never holds a byte back.
  kvcp_parser #(
    .VAL_MAX(VAL_MAX)
  ) u_parser (
    .clk   (clk),
    .rst   (rst),
    .accept(accept),
    .data  (byte_data),
    .push  (push)
  );

  // Result queue decouples the two channels and spreads paired writes.
  kvcp_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (queue_full),
    .valid(result_valid),
    .stall(result_stall),
    .data (result_data)
  );

endmodule

// File: test/key_value_config_line_parser_test.sv
// ----------------------------------------------------------------------------
// key_value_config_line_parser_test: self-checking bench of the line parser
// Feeds configuration text one byte per transfer and keeps its own model of
// the parser. The model predicts the string and ink table writes of every
// byte, and each write that comes out is compared with the oldest
// prediction. Directed buffers cover the keys and the corner cases of the
// parser. Random buffers follow, made mostly of well-formed lines with
// random values. Both channels idle in random bursts, except in the final
// stretch of the run.
// ----------------------------------------------------------------------------
module key_value_config_line_parser_test;
  import kvcp_pkg::*;

  // The string limit of the instance. The model below uses the same value.
  localparam int STRING_LIMIT = VAL_MAX_DEFAULT;

  // Character codes that steer the parser.
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Key indexes. For the three string keys the index is also the target.
  localparam int KEY_ICONS  = 0;
  localparam int KEY_FONT   = 1;
  localparam int KEY_CURSOR = 2;
  localparam int KEY_INKS   = 3;
  localparam int KEY_COUNT  = 4;

  localparam int INK_CAP   = 26;
  localparam int PEN_COUNT = 5;

  localparam int RANDOM_ITEMS = 1050;
  localparam int TAIL_ITEMS   = 150;
  localparam int SETTLE_CYCLES = 8;

  typedef enum logic [2:0] {
    MODE_LINE_START,
    MODE_SKIP_LINE,
    MODE_KEY_MATCH,
    MODE_STRING_COPY,
    MODE_INK_PARSE
  } parse_mode_e;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    byte_valid = 1'b0;
  logic    byte_stall;
  byte_t   byte_data = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result_data;

  key_value_config_line_parser #(
    .VAL_MAX(STRING_LIMIT)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .byte_data   (byte_data),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_data (result_data)
  );

  // Writes predicted but not yet seen on the result channel, oldest first.
  result_t expected_writes[$];
  // Writes predicted for the byte that is being modeled right now.
  result_t byte_writes[$];

  int  mismatch_count = 0;
  // Bytes transferred so far; they pace the random part.
  int  sent_items = 0;
  // When set, neither side idles.
  bit  quiet = 1'b0;
  int  stall_left = 0;

  // Model state of the parser.
  parse_mode_e mode_now = MODE_LINE_START;
  logic [2:0]  key_index = '0;
  logic [3:0]  key_match_mask = 4'hF;
  logic [1:0]  string_target = '0;
  int          chars_written = 0;
  int          pen_now = 0;
  int          ink_value = 0;
  bit          has_digit = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Model of the parser
  // --------------------------------------------------------------------------

  function automatic string key_word(input int k);
    case (k)
      KEY_ICONS:  return "ICONS=";
      KEY_FONT:   return "FONT=";
      KEY_CURSOR: return "CURSOR=";
      default:    return "INKS=";
    endcase
  endfunction

  function automatic bit is_line_end(input logic [7:0] c);
    return c == CHAR_CR || c == CHAR_LF;
  endfunction

  task automatic add_write(input logic [1:0] tgt, input int pos, input int val);
    result_t w;
    w.target      = tgt;
    w.position    = pos[4:0];
    w.value       = val[7:0];
    w.last_of_run = 1'b0;
    byte_writes.push_back(w);
  endtask

  task automatic clear_parse_state();
    mode_now       = MODE_LINE_START;
    key_index      = '0;
    key_match_mask = 4'hF;
    string_target  = '0;
    chars_written  = 0;
    pen_now        = 0;
    ink_value      = 0;
    has_digit      = 1'b0;
  endtask

  // A key has matched in full: set up the value that follows it.
  task automatic begin_value(input int k);
    if (k == KEY_INKS) begin
      mode_now  = MODE_INK_PARSE;
      pen_now   = 0;
      ink_value = 0;
      has_digit = 1'b0;
    end else begin
      string_target = k[1:0];
      chars_written = 0;
      mode_now      = MODE_STRING_COPY;
    end
  endtask

  // Narrows the set of keys that still agree with the line so far.
  task automatic match_key_byte(input logic [7:0] c);
    logic [3:0] keep;
    string      word;
    int         k;
    keep = '0;
    for (k = 0; k < KEY_COUNT; k++) begin
      word = key_word(k);
      if (key_match_mask[k] && key_index < word.len() && word[key_index] == c)
        keep[k] = 1'b1;
    end
    key_match_mask = keep;
    key_index      = key_index + 3'd1;
    if (keep == '0) begin
      mode_now = is_line_end(c) ? MODE_LINE_START : MODE_SKIP_LINE;
    end else begin
      for (k = 0; k < KEY_COUNT; k++) begin
        word = key_word(k);
        if (keep[k] && word.len() == key_index) begin
          begin_value(k);
          break;
        end
      end
    end
  endtask

  // Works out the writes of one transferred byte and queues them.
  task automatic predict_writes(input byte_t item);
    logic [7:0] c;
    c = item.text_byte;
    byte_writes.delete();
    sent_items++;

    case (mode_now)
      MODE_LINE_START: begin
        if (is_line_end(c)) begin
          // Blank line: nothing to do.
        end else if (c == CHAR_HASH) begin
          mode_now = MODE_SKIP_LINE;
        end else begin
          key_match_mask = 4'hF;
          key_index      = '0;
          mode_now       = MODE_KEY_MATCH;
          match_key_byte(c);
        end
      end
      MODE_KEY_MATCH: match_key_byte(c);
      MODE_STRING_COPY: begin
        if (c == CHAR_NUL || is_line_end(c)) begin
          add_write(string_target, chars_written, 0);
          mode_now = is_line_end(c) ? MODE_LINE_START : MODE_SKIP_LINE;
        end else begin
          add_write(string_target, chars_written, c);
          chars_written++;
          // The byte that fills the string also writes the terminator.
          if (chars_written >= STRING_LIMIT) begin
            add_write(string_target, chars_written, 0);
            mode_now = MODE_SKIP_LINE;
          end
        end
      end
      MODE_INK_PARSE: begin
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
          // Saturate instead of wrapping on long numbers.
          ink_value = ink_value * 10 + int'(c - CHAR_ZERO);
          if (ink_value > INK_CAP)
            ink_value = INK_CAP;
          has_digit = 1'b1;
        end else begin
          if (has_digit)
            add_write(TARGET_INKS, pen_now, ink_value);
          has_digit = 1'b0;
          ink_value = 0;
          if (is_line_end(c)) begin
            mode_now = MODE_LINE_START;
          end else if (c == CHAR_COMMA) begin
            pen_now++;
            if (pen_now >= PEN_COUNT)
              mode_now = MODE_SKIP_LINE;
          end else begin
            mode_now = MODE_SKIP_LINE;
          end
        end
      end
      default: begin
        if (is_line_end(c))
          mode_now = MODE_LINE_START;
      end
    endcase

    // The final byte of a buffer closes any pending value.
    if (item.end_of_buffer) begin
      if (mode_now == MODE_STRING_COPY)
        add_write(string_target, chars_written, 0);
      else if (mode_now == MODE_INK_PARSE && has_digit)
        add_write(TARGET_INKS, pen_now, ink_value);
      clear_parse_state();
    end

    if (byte_writes.size() > 0)
      byte_writes[byte_writes.size() - 1].last_of_run = 1'b1;
    foreach (byte_writes[i])
      expected_writes.push_back(byte_writes[i]);
  endtask

  // --------------------------------------------------------------------------
  // Byte channel
  // --------------------------------------------------------------------------

  // Offers one byte and returns once it has been transferred. Valid stays high
  // on return so that the next byte can follow with no bubble; a gap lowers it
  // at the start of the next call.
  task automatic send_byte(input logic [7:0] c, input bit last);
    byte_t item;
    int    gap;
    item.text_byte     = c;
    item.end_of_buffer = last;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 14);
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_data  <= item;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    predict_writes(item);
  endtask

  // Sends a string of text; last marks its final character as end of buffer.
  task automatic send_text(input string s, input bit last);
    int i;
    for (i = 0; i < s.len(); i++)
      send_byte(s[i], last && i == s.len() - 1);
  endtask

  // Drops valid and waits for a clock edge so that it cannot be raised again in
  // the same time step.
  task automatic idle_byte_channel();
    byte_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_for_drain();
    while (expected_writes.size() != 0) @(posedge clk);
  endtask

  // Builds one random line and sends it. Most lines are well formed with
  // random content; the rest are comments, blanks, noise and broken keys.
  task automatic send_random_line();
    logic [7:0] text[$];
    string      word;
    int         kind, len, nfields, ndig, term, eob_at, i, f;
    text.delete();
    eob_at = -1;
    kind = $urandom_range(0, 9);
    if (kind <= 2) begin
      text.push_back(CHAR_NUL);
      text.delete();
      word = key_word($urandom_range(KEY_ICONS, KEY_CURSOR));
      for (i = 0; i < word.len(); i++) text.push_back(word[i]);
      // Lengths past the limit are common enough to hit it often.
      len = $urandom_range(0, STRING_LIMIT + 4);
      for (i = 0; i < len; i++) begin
        if ($urandom_range(0, 11) == 0)
          text.push_back($urandom_range(0, 1) ? CHAR_NUL : 8'($urandom_range(128, 255)));
        else
          text.push_back(8'($urandom_range(32, 126)));
      end
    end else if (kind <= 5) begin
      word = key_word(KEY_INKS);
      for (i = 0; i < word.len(); i++) text.push_back(word[i]);
      nfields = $urandom_range(1, PEN_COUNT + 1);
      for (f = 0; f < nfields; f++) begin
        ndig = $urandom_range(0, 4);
        for (i = 0; i < ndig; i++)
          text.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 9) == 0)
          text.push_back(8'($urandom_range(32, 126)));
        else if (f < nfields - 1 || $urandom_range(0, 3) == 0)
          text.push_back(CHAR_COMMA);
      end
    end else if (kind == 6) begin
      text.push_back(CHAR_HASH);
      len = $urandom_range(0, 6);
      for (i = 0; i < len; i++) text.push_back(8'($urandom_range(32, 126)));
    end else if (kind == 7) begin
      // Blank line: the terminator alone.
    end else if (kind == 8) begin
      len = $urandom_range(1, 12);
      for (i = 0; i < len; i++) text.push_back(8'($urandom_range(0, 255)));
    end else begin
      word = key_word($urandom_range(KEY_ICONS, KEY_INKS));
      len = $urandom_range(1, word.len() - 1);
      for (i = 0; i < len; i++) text.push_back(word[i]);
      text.push_back(8'($urandom_range(0, 255)));
    end

    term = $urandom_range(0, 5);
    case (term)
      0, 1: text.push_back(CHAR_LF);
      2: text.push_back(CHAR_CR);
      3: begin
        text.push_back(CHAR_CR);
        text.push_back(CHAR_LF);
      end
      4: begin
        // The buffer ends with this line, with no terminator.
        if (text.size() == 0) text.push_back(8'($urandom_range(32, 126)));
        eob_at = text.size() - 1;
      end
      default: begin
        text.push_back(CHAR_LF);
        eob_at = text.size() - 1;
      end
    endcase
    // Now and then the buffer ends in the middle of a line.
    if (eob_at < 0 && $urandom_range(0, 24) == 0)
      eob_at = $urandom_range(0, text.size() - 1);

    for (i = 0; i < text.size(); i++)
      send_byte(text[i], i == eob_at);
  endtask

  // --------------------------------------------------------------------------
  // Result channel: checks each transfer against the oldest prediction and
  // stalls in random bursts.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    result_t want;
    bit      stall_next;
    if (rst) begin
      stall_left = 0;
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_writes.size() == 0) begin
          $display("%0t: write with none expected: target %0d position %0d value %0d last %0b",
                   $time, result_data.target, result_data.position, result_data.value,
                   result_data.last_of_run);
          mismatch_count++;
        end else begin
          want = expected_writes.pop_front();
          if (result_data.target !== want.target || result_data.position !== want.position ||
              result_data.value !== want.value ||
              result_data.last_of_run !== want.last_of_run) begin
            $display({"%0t: write mismatch: expected target %0d position %0d value %0d ",
                      "last %0b, actual target %0d position %0d value %0d last %0b"},
                     $time, want.target, want.position, want.value, want.last_of_run,
                     result_data.target, result_data.position, result_data.value,
                     result_data.last_of_run);
            mismatch_count++;
          end
        end
      end

      if (stall_left > 0) begin
        stall_left--;
        stall_next = 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        stall_next = 1'b1;
      end else begin
        stall_next = 1'b0;
      end
      result_stall <= stall_next;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Field extremes, comments, blank lines, the CURSOR= and FONT= keys and the ends of buffers.
  task automatic test_directed_cases();
    // A NUL at the start of a line matches no key; the line is skipped.
    send_byte(CHAR_NUL, 1'b0);
    send_byte(CHAR_LF, 1'b0);
    // A comment ended by CR, then a blank line.
    send_text("#C", 1'b0);
    send_byte(CHAR_CR, 1'b0);
    send_byte(CHAR_LF, 1'b0);
    // The top byte value is copied into a string; NUL then ends the value.
    send_text("CURSOR=", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CHAR_NUL, 1'b0);
    send_byte(CHAR_LF, 1'b0);
    // The key completes on the final byte: only a terminator at position 0.
    send_text("FONT=", 1'b1);
    // The buffer ends inside a key: nothing is written.
    send_text("CU", 1'b1);
    // The buffer ends inside a value: the character and the terminator.
    send_text("FONT=q", 1'b1);
  endtask

  // The byte that fills the string writes the terminator; the rest is skipped.
  task automatic test_string_limit();
    send_text("ICONS=0123456789abcdefZ", 1'b0);
    send_byte(CHAR_LF, 1'b0);
  endtask

  // Saturation, empty fields, fields ended by junk, by a line end, by the
  // comma after the fifth pen and by the final byte.
  task automatic test_ink_table();
    send_text("INKS=99,,5x", 1'b0);
    send_byte(CHAR_LF, 1'b0);
    send_text("INKS=0,1,2,3,4,9", 1'b0);
    send_byte(CHAR_CR, 1'b0);
    send_text("INKS=12", 1'b0);
    send_byte(CHAR_LF, 1'b0);
    send_text("INKS=7", 1'b1);
  endtask

  // Random buffers with idling on both sides. Now and then the sender holds
  // off until every pending write has come out.
  task automatic test_random_buffers();
    int goal, lines;
    goal  = sent_items + RANDOM_ITEMS;
    lines = 0;
    while (sent_items < goal) begin
      send_random_line();
      lines++;
      if (lines % 60 == 30) begin
        idle_byte_channel();
        wait_for_drain();
      end
    end
  endtask

  // Final stretch at full rate: no gaps and no stalls.
  task automatic test_quiet_tail();
    int goal;
    quiet = 1'b1;
    goal  = sent_items + TAIL_ITEMS;
    while (sent_items < goal)
      send_random_line();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_string_limit();
    test_ink_table();
    test_random_buffers();
    test_quiet_tail();

    // Let the last writes arrive, then keep the clock running to catch strays.
    idle_byte_channel();
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_writes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
